// ===== design/sha256_merkle_subtree_root_macros.svh =====
// Assertion macros used by the checker of the Merkle subtree root block.
`ifndef SHA256_MERKLE_SUBTREE_ROOT_MACROS_SVH
`define SHA256_MERKLE_SUBTREE_ROOT_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define SMR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its trigger.
`define SMR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/smr_pkg.sv =====
package smr_pkg;

   localparam int RAM_AW    = 7;
   localparam int RAM_DEPTH = 1 << RAM_AW;

   localparam logic REGION_STACK   = 1'b0;
   localparam logic REGION_SIBLING = 1'b1;

   localparam logic HASH_KIND_ROOT    = 1'b0;
   localparam logic HASH_KIND_SIBLING = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   localparam logic [3:0] TOP_LEVEL = 4'd15;

   localparam logic [255:0] INIT_HV = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   // 22-byte ASCII domain prefix of every leaf message
   localparam logic [175:0] LEAF_PREFIX =
      176'h4359_4245_5253_5041_4345_5F53_4944_4553_5445_505F_5631;

   // second block of a 64-byte message: pad marker and bit length 512
   localparam logic [511:0] PAD_BLOCK = {8'h80, 440'd0, 64'd512};

   typedef enum logic [3:0] {
      ST_IDLE, ST_OVF, ST_LEAF_GO, ST_LEAF_WAIT, ST_CHECK, ST_SIB,
      ST_LEFT_RD, ST_LEFT_LAST, ST_PAR1_GO, ST_PAR1_WAIT, ST_PAR2_GO,
      ST_PAR2_WAIT, ST_PUSH, ST_OUT_RD, ST_OUT_CAP
   } smr_state_type;

   typedef struct packed {
      logic              start;
      logic [255:0]      iv;
      logic [511:0]      block;
   } sha_cmd_type;

   typedef struct packed {
      logic              done;
      logic [255:0]      digest;
   } sha_rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [RAM_AW-1:0] wr_addr;
      logic [63:0]       wr_data;
      logic              rd_en;
      logic [RAM_AW-1:0] rd_addr;
   } ram_cmd_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   // Single padded block: prefix, minimal big-endian value bytes, pad, length.
   function automatic logic [511:0] leaf_block(input logic [63:0] val);
      int          n;
      int          j;
      logic [511:0] blk;
      n   = 1;
      blk = '0;
      for (j = 1; j < 8; j++) begin
         if (val[j*8 +: 8] != 8'd0) n = j + 1;
      end
      blk[511 -: 176] = LEAF_PREFIX;
      for (j = 0; j < 9; j++) begin
         if (j < n) begin
            blk[511 - 8*(22 + j) -: 8] = val[8*(n - 1 - j) +: 8];
         end else if (j == n) begin
            blk[511 - 8*(22 + j) -: 8] = 8'h80;
         end
      end
      blk[63:0] = 64'((22 + n) * 8);
      return blk;
   endfunction

endpackage

// ===== design/smr_hash_ram.sv =====
module smr_hash_ram
   import smr_pkg::*;
(
   input  logic        clock,
   input  ram_cmd_type cmd,
   output logic [63:0] rd_data
);

   // words 0..63 hold the level stack, 64..127 the proof siblings
   logic [63:0] mem [RAM_DEPTH];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/smr_sha_core.sv =====
module smr_sha_core
   import smr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  sha_cmd_type cmd,
   output sha_rsp_type rsp
);

   logic [31:0]  v_ff [8];
   logic [31:0]  w_ff [16];
   logic [255:0] hv_ff;
   logic [255:0] digest_ff;
   logic [5:0]   round_ff;
   logic         busy_ff;
   logic         fin_ff;
   logic         done_ff;

   logic [31:0]  t1_in;
   logic [31:0]  t2_in;
   logic [31:0]  w_new_in;

   always_comb begin
      t1_in = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
            + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + round_k(round_ff) + w_ff[0];
      t2_in = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
            + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      w_new_in = (rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10)) + w_ff[9]
               + (rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3)) + w_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= busy_ff && (round_ff == 6'd63);
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (round_ff == 6'd63) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         hv_ff    <= cmd.iv;
         round_ff <= 6'd0;
         for (int k = 0; k < 8; k++) v_ff[k] <= cmd.iv[255 - 32*k -: 32];
         for (int k = 0; k < 16; k++) w_ff[k] <= cmd.block[511 - 32*k -: 32];
      end else if (busy_ff) begin
         round_ff <= round_ff + 6'd1;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1_in;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1_in + t2_in;
         // slide the message schedule window
         for (int k = 0; k < 15; k++) w_ff[k] <= w_ff[k+1];
         w_ff[15] <= w_new_in;
      end
      if (fin_ff) begin
         for (int k = 0; k < 8; k++) begin
            digest_ff[255 - 32*k -: 32] <= hv_ff[255 - 32*k -: 32] + v_ff[k];
         end
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.digest = digest_ff;

endmodule

// ===== design/smr_ctrl.sv =====
module smr_ctrl
   import smr_pkg::*;
#(
   parameter int MAX_TREE_HEIGHT = 15
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_base_value,
   input  logic [3:0]   req_tree_height,
   input  logic         req_want_proof,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic         rsp_status,
   output logic         rsp_hash_kind,
   output logic [3:0]   rsp_proof_level,
   output logic [1:0]   rsp_word_index,
   output logic [63:0]  rsp_hash_word,
   output logic         rsp_last_word,
   output sha_cmd_type  sha_cmd,
   input  sha_rsp_type  sha_rsp,
   output ram_cmd_type  ram_cmd,
   input  logic [63:0]  ram_rd_data
);

   smr_state_type state_ff, state_in;

   logic [3:0]  h_ff;
   logic        proof_ff;
   logic [63:0] val_ff;
   logic [15:0] leaf_idx_ff;
   logic [15:0] full_ff;
   logic [3:0]  taken_ff;
   logic [3:0]  lvl_ff;
   logic [1:0]  wcnt_ff;
   logic [63:0] cur_ff [4];
   logic [63:0] left_ff [4];
   logic        rd_valid_ff;
   logic [1:0]  rd_idx_ff;
   logic        out_kind_ff;
   logic [3:0]  out_lvl_ff;

   logic        rsp_valid_ff;
   logic        rsp_status_ff;
   logic        rsp_kind_ff;
   logic [3:0]  rsp_lvl_ff;
   logic [1:0]  rsp_widx_ff;
   logic [63:0] rsp_word_ff;
   logic        rsp_last_ff;

   logic        accept_in;
   logic [3:0]  h_sat_in;
   logic [64:0] span_in;
   logic        ovf_in;
   logic        slot_free_in;
   logic        take_sib_in;
   logic        leaf_final_in;
   logic        out_last_in;
   logic [15:0] leaf_mask_in;

   always_comb begin
      h_sat_in     = (req_tree_height > 4'(MAX_TREE_HEIGHT)) ? 4'(MAX_TREE_HEIGHT)
                                                              : req_tree_height;
      span_in      = {1'b0, req_base_value} + {49'd0, ((16'd1 << h_sat_in) - 16'd1)};
      ovf_in       = span_in[64];
      accept_in    = req_tvalid && req_tready;
      slot_free_in = !rsp_valid_ff || rsp_tready;
      take_sib_in  = proof_ff && (taken_ff == lvl_ff) && (lvl_ff != TOP_LEVEL);
      leaf_mask_in = (16'd1 << h_ff) - 16'd1;
      leaf_final_in = (leaf_idx_ff == leaf_mask_in);
      if (out_kind_ff == HASH_KIND_ROOT) begin
         out_last_in = (wcnt_ff == 2'd3) && !(proof_ff && (h_ff != 4'd0));
      end else begin
         out_last_in = (wcnt_ff == 2'd3) && ({1'b0, out_lvl_ff} + 5'd1 == {1'b0, h_ff});
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (accept_in) state_in = ovf_in ? ST_OVF : ST_LEAF_GO;
         ST_OVF:       if (slot_free_in) state_in = ST_IDLE;
         ST_LEAF_GO:   state_in = ST_LEAF_WAIT;
         ST_LEAF_WAIT: if (sha_rsp.done) state_in = ST_CHECK;
         ST_CHECK: begin
            if (!full_ff[lvl_ff]) state_in = ST_PUSH;
            else if (take_sib_in) state_in = ST_SIB;
            else state_in = ST_LEFT_RD;
         end
         ST_SIB:       if (wcnt_ff == 2'd3) state_in = ST_LEFT_RD;
         ST_LEFT_RD:   if (wcnt_ff == 2'd3) state_in = ST_LEFT_LAST;
         ST_LEFT_LAST: state_in = ST_PAR1_GO;
         ST_PAR1_GO:   state_in = ST_PAR1_WAIT;
         ST_PAR1_WAIT: if (sha_rsp.done) state_in = ST_PAR2_GO;
         ST_PAR2_GO:   state_in = ST_PAR2_WAIT;
         ST_PAR2_WAIT: if (sha_rsp.done) state_in = ST_CHECK;
         ST_PUSH: begin
            if (wcnt_ff == 2'd3) state_in = leaf_final_in ? ST_OUT_RD : ST_LEAF_GO;
         end
         ST_OUT_RD:    if (slot_free_in) state_in = ST_OUT_CAP;
         ST_OUT_CAP:   state_in = out_last_in ? ST_IDLE : ST_OUT_RD;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs toward the hash core and the memory
   always_comb begin
      req_tready      = (state_ff == ST_IDLE);
      sha_cmd.start   = 1'b0;
      sha_cmd.iv      = INIT_HV;
      sha_cmd.block   = PAD_BLOCK;
      ram_cmd.wr_en   = 1'b0;
      ram_cmd.wr_addr = {REGION_STACK, lvl_ff, wcnt_ff};
      ram_cmd.wr_data = cur_ff[wcnt_ff];
      ram_cmd.rd_en   = 1'b0;
      ram_cmd.rd_addr = {REGION_STACK, lvl_ff, wcnt_ff};
      case (state_ff)
         ST_LEAF_GO: begin
            sha_cmd.start = 1'b1;
            sha_cmd.block = leaf_block(val_ff);
         end
         ST_PAR1_GO: begin
            sha_cmd.start = 1'b1;
            sha_cmd.block = {left_ff[0], left_ff[1], left_ff[2], left_ff[3],
                             cur_ff[0], cur_ff[1], cur_ff[2], cur_ff[3]};
         end
         ST_PAR2_GO: begin
            sha_cmd.start = 1'b1;
            sha_cmd.iv    = sha_rsp.digest;
         end
         ST_SIB: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = {REGION_SIBLING, lvl_ff, wcnt_ff};
         end
         ST_PUSH:    ram_cmd.wr_en = 1'b1;
         ST_LEFT_RD: ram_cmd.rd_en = 1'b1;
         ST_OUT_RD: begin
            ram_cmd.rd_en   = slot_free_in;
            ram_cmd.rd_addr = (out_kind_ff == HASH_KIND_ROOT)
                            ? {REGION_STACK, h_ff, wcnt_ff}
                            : {REGION_SIBLING, out_lvl_ff, wcnt_ff};
         end
         default: begin
            ram_cmd.rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= (state_ff == ST_LEFT_RD);
         if ((state_ff == ST_OVF && slot_free_in) || state_ff == ST_OUT_CAP) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= wcnt_ff;
      if (rd_valid_ff) left_ff[rd_idx_ff] <= ram_rd_data;
      case (state_ff)
         ST_IDLE: begin
            h_ff        <= h_sat_in;
            proof_ff    <= req_want_proof;
            val_ff      <= req_base_value;
            leaf_idx_ff <= 16'd0;
            full_ff     <= 16'd0;
            taken_ff    <= 4'd0;
            wcnt_ff     <= 2'd0;
         end
         ST_OVF: begin
            if (slot_free_in) begin
               rsp_status_ff <= STATUS_OVERFLOW;
               rsp_kind_ff   <= HASH_KIND_ROOT;
               rsp_lvl_ff    <= 4'd0;
               rsp_widx_ff   <= 2'd0;
               rsp_word_ff   <= 64'd0;
               rsp_last_ff   <= 1'b1;
            end
         end
         ST_LEAF_WAIT: begin
            if (sha_rsp.done) begin
               for (int k = 0; k < 4; k++) cur_ff[k] <= sha_rsp.digest[255 - 64*k -: 64];
               lvl_ff <= 4'd0;
            end
         end
         ST_SIB: begin
            wcnt_ff <= wcnt_ff + 2'd1;
            if (wcnt_ff == 2'd3) taken_ff <= taken_ff + 4'd1;
         end
         ST_LEFT_RD: wcnt_ff <= wcnt_ff + 2'd1;
         ST_PAR2_WAIT: begin
            if (sha_rsp.done) begin
               for (int k = 0; k < 4; k++) cur_ff[k] <= sha_rsp.digest[255 - 64*k -: 64];
               full_ff[lvl_ff] <= 1'b0;
               lvl_ff          <= lvl_ff + 4'd1;
            end
         end
         ST_PUSH: begin
            wcnt_ff <= wcnt_ff + 2'd1;
            if (wcnt_ff == 2'd3) begin
               full_ff[lvl_ff] <= 1'b1;
               leaf_idx_ff     <= leaf_idx_ff + 16'd1;
               val_ff          <= val_ff + 64'd1;
               out_kind_ff     <= HASH_KIND_ROOT;
               out_lvl_ff      <= 4'd0;
            end
         end
         ST_OUT_CAP: begin
            rsp_status_ff <= STATUS_OK;
            rsp_kind_ff   <= out_kind_ff;
            rsp_lvl_ff    <= (out_kind_ff == HASH_KIND_ROOT) ? 4'd0 : out_lvl_ff;
            rsp_widx_ff   <= wcnt_ff;
            rsp_word_ff   <= ram_rd_data;
            rsp_last_ff   <= out_last_in;
            wcnt_ff       <= wcnt_ff + 2'd1;
            if (wcnt_ff == 2'd3) begin
               // root done: move on to the siblings; else climb one level
               if (out_kind_ff == HASH_KIND_ROOT) begin
                  out_kind_ff <= HASH_KIND_SIBLING;
                  out_lvl_ff  <= 4'd0;
               end else begin
                  out_lvl_ff <= out_lvl_ff + 4'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_hash_kind   = rsp_kind_ff;
   assign rsp_proof_level = rsp_lvl_ff;
   assign rsp_word_index  = rsp_widx_ff;
   assign rsp_hash_word   = rsp_word_ff;
   assign rsp_last_word   = rsp_last_ff;

endmodule

// ===== design/sha256_merkle_subtree_root.sv =====
// Merkle subtree root engine over SHA-256. An item names a subtree
// of 2^height leaves starting at a 64-bit base value; each leaf is hashed
// over a fixed 22-byte domain prefix plus the value's minimal big-endian
// bytes, and parents are SHA-256 of left||right. The block answers with the
// root as four 64-bit words, most significant first, and, when the proof
// flag is set, the siblings of leaf 0 from level 0 upward, four words each;
// tlast marks the final word. A subtree whose last leaf passes 2^64-1 gives
// one result with the overflow status set. One item is in work at a time:
// a single iterative SHA-256 unit doing one round per cycle sets the pace.
// Per-level carry hashes and proof siblings live in a 128 x 64-bit memory
// with a registered read; the sequencer never reads and writes the same
// word in one cycle.
module sha256_merkle_subtree_root
   import smr_pkg::*;
#(
   parameter int MAX_TREE_HEIGHT = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [63:0] base_value, [67:64] tree_height, rest zero
   input  logic        req_tuser,   // [0] want_proof
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [3:0] proof_level, [5:4] word_index,
                                    // [69:6] hash_word, rest zero
   output logic [1:0]  rsp_tuser,   // [0] status, [1] hash_kind
   output logic        rsp_tlast    // last_word
);

   sha_cmd_type sha_cmd;
   sha_rsp_type sha_rsp;
   ram_cmd_type ram_cmd;
   logic [63:0] ram_rd_data;

   logic        rsp_status;
   logic        rsp_hash_kind;
   logic [3:0]  rsp_proof_level;
   logic [1:0]  rsp_word_index;
   logic [63:0] rsp_hash_word;

   // sequencer: leaf walk, carry stack folding, result readout
   smr_ctrl #(
      .MAX_TREE_HEIGHT(MAX_TREE_HEIGHT)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_base_value  (req_tdata[63:0]),
      .req_tree_height (req_tdata[67:64]),
      .req_want_proof  (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_status      (rsp_status),
      .rsp_hash_kind   (rsp_hash_kind),
      .rsp_proof_level (rsp_proof_level),
      .rsp_word_index  (rsp_word_index),
      .rsp_hash_word   (rsp_hash_word),
      .rsp_last_word   (rsp_tlast),
      .sha_cmd         (sha_cmd),
      .sha_rsp         (sha_rsp),
      .ram_cmd         (ram_cmd),
      .ram_rd_data     (ram_rd_data)
   );

   // one SHA-256 round per cycle
   smr_sha_core u_sha (
      .clock (clock),
      .reset (reset),
      .cmd   (sha_cmd),
      .rsp   (sha_rsp)
   );

   // carry stack and sibling words
   smr_hash_ram u_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .rd_data (ram_rd_data)
   );

   // pack the result fields, lowest field in the lowest bits
   assign rsp_tdata = {2'b00, rsp_hash_word, rsp_word_index, rsp_proof_level};
   assign rsp_tuser = {rsp_hash_kind, rsp_status};

endmodule

// ===== design/smr_checker.sv =====
`include "sha256_merkle_subtree_root_macros.svh"

module smr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // an overflow answer is a lone, empty root item
   `SMR_ASSERT_NOW(a_ovf_alone, rsp_tvalid && rsp_tuser[0],
      rsp_tlast && (rsp_tdata == 72'd0) && !rsp_tuser[1], "overflow item malformed")

   // root words always carry level zero
   `SMR_ASSERT_NOW(a_root_level, rsp_tvalid && !rsp_tuser[1],
      rsp_tdata[3:0] == 4'd0, "root item with nonzero level")

   // a hash answer only ends on the final word of a hash
   `SMR_ASSERT_NOW(a_last_word3, rsp_tvalid && rsp_tlast && !rsp_tuser[0],
      rsp_tdata[5:4] == 2'd3, "last item not on word three")

   // a stalled item holds
   `SMR_ASSERT_NEXT(a_stall_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "stalled item changed")

endmodule

bind sha256_merkle_subtree_root smr_checker u_smr_checker (.*);
